### rtl/calclk_pkg.sv
// Package for the calendar clock counter: shared types, reset values and
// calendar helper functions (month lengths, Gregorian leap rule).
// No dependencies; compiled before every other file of the block.
package calclk_pkg;

	// Command codes carried on the command channel
	typedef enum logic [1:0] {
		MODE_TICK_MS  = 2'd0,
		MODE_TICK_SEC = 2'd1,
		MODE_SET      = 2'd2,
		MODE_SYNC     = 2'd3
	} calclk_mode_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_LEAP,
		ST_LOAD,
		ST_DONE
	} calclk_state_t;

	// Date and time as held in the counter
	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [2:0]  weekday;
	} calclk_time_t;

	// Widths
	localparam int unsigned CntW = 17;   // millis remainder + elapsed fits 17 bits
	localparam int unsigned MsW  = 10;

	// Reset values
	localparam logic [15:0] YEAR_RESET    = 16'd1970;
	localparam logic [3:0]  MONTH_RESET   = 4'd1;
	localparam logic [4:0]  DAY_RESET     = 5'd1;
	localparam logic [2:0]  WEEKDAY_RESET = 3'd4;

	// Limits
	localparam logic [CntW-1:0] MS_PER_SEC  = 17'd1000;
	localparam logic [CntW-1:0] ONE_SEC     = 17'd1;
	localparam logic [5:0]      LAST_SECOND = 6'd59;
	localparam logic [5:0]      LAST_MINUTE = 6'd59;
	localparam logic [4:0]      LAST_HOUR   = 5'd23;
	localparam logic [3:0]      LAST_MONTH  = 4'd12;
	localparam logic [2:0]      LAST_WDAY   = 3'd7;

	// Divisibility by 25 through the multiplicative inverse modulo 2^k:
	// x is a multiple of 25 iff (x * inv25) mod 2^k <= (2^k - 1) / 25
	localparam logic [13:0] INV25_14 = 14'd7209;
	localparam logic [13:0] LIM25_14 = 14'd655;
	localparam logic [11:0] INV25_12 = 12'd3113;
	localparam logic [11:0] LIM25_12 = 12'd163;

	// Gregorian leap rule: multiple of 400, or multiple of 4 but not of 100
	function automatic logic leap_year(input logic [15:0] y);
		logic [27:0] p14;
		logic [23:0] p12;
		logic        div4;
		logic        div100;
		logic        div400;
		p14    = y[15:2] * INV25_14;
		p12    = y[15:4] * INV25_12;
		div4   = (y[1:0] == 2'd0);
		div100 = div4 && (p14[13:0] <= LIM25_14);
		div400 = (y[3:0] == 4'd0) && (p12[11:0] <= LIM25_12);
		return div400 || (div4 && !div100);
	endfunction

	// Days in a month; zero for a month code outside 1..12
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
			4'd2:                                       d = leap ? 5'd29 : 5'd28;
			default:                                    d = 5'd0;
		endcase
		return d;
	endfunction

endpackage

### rtl/calclk_cmd_if.sv
// Command channel of the calendar clock counter: valid/ready plus the
// command fields. Depends on nothing.
interface calclk_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [15:0] elapsed;
	logic [15:0] new_year;
	logic [3:0]  new_month;
	logic [4:0]  new_day;
	logic [4:0]  new_hour;
	logic [5:0]  new_minute;
	logic [5:0]  new_second;
	logic [2:0]  new_weekday;

	modport source (
		output valid, mode, elapsed, new_year, new_month, new_day,
		       new_hour, new_minute, new_second, new_weekday,
		input  ready
	);
	modport sink (
		input  valid, mode, elapsed, new_year, new_month, new_day,
		       new_hour, new_minute, new_second, new_weekday,
		output ready
	);
endinterface

### rtl/calclk_res_if.sv
// Result channel of the calendar clock counter: valid/ready plus the
// date, time, millisecond remainder and accepted flag. Depends on nothing.
interface calclk_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [2:0]  weekday;
	logic [9:0]  millis;
	logic        accepted;

	modport source (
		output valid, year, month, day, hour, minute, second, weekday,
		       millis, accepted,
		input  ready
	);
	modport sink (
		input  valid, year, month, day, hour, minute, second, weekday,
		       millis, accepted,
		output ready
	);
endinterface

### rtl/calendar_clock_counter_core.sv
// Calendar clock counter core: Gregorian date/time with millisecond remainder.
// Depends on calclk_pkg, calclk_cmd_if and calclk_res_if.
//
// cmd (sink): one command per transfer. mode selects tick milliseconds, tick
// seconds, set date/time (keeps the remainder) or sync date/time (clears the
// remainder). Loads are range checked; a bad load changes nothing and reports
// accepted = 0. res (source): exactly one result per command, the state after it.
// One command at a time. A single incrementer advances the calendar by one
// second per cycle, paced by a down-counter with a shared compare/subtract.
// A set or sync first checks the leap status of the new year, then commits.
// The command channel is ready again in the cycle the result is first offered.
// Reset: arst_n clears to 1970-01-01 00:00:00, weekday 4, remainder 0; no
// clearing pass is needed.
// Stall: the result is held in an output register. While it is not taken, a
// new command is still accepted and worked on; its result waits in the final
// state until the output register frees up.
module calendar_clock_counter_core (
	input logic            clk,
	input logic            arst_n,
	calclk_cmd_if.sink     cmd,
	calclk_res_if.source   res
);

	calclk_pkg::calclk_state_t state_q, state_d;
	calclk_pkg::calclk_mode_t  mode_q;
	calclk_pkg::calclk_time_t  cur_q, ld_q, adv;
	logic [calclk_pkg::CntW-1:0] cnt_q, step_amt;
	logic [calclk_pkg::MsW-1:0]  rem_q;
	logic                        leap_q;
	logic                        acc_q;

	logic                        res_valid_q;
	calclk_pkg::calclk_time_t    res_time_q;
	logic [calclk_pkg::MsW-1:0]  res_ms_q;
	logic                        res_acc_q;

	logic       cmd_xfer, step_go, step_end, load_ok, res_load, res_free, is_load;
	logic [4:0] cur_dim, ld_dim;
	logic [15:0] leap_src;

	// Handshakes
	assign cmd.ready = (state_q == calclk_pkg::ST_IDLE);
	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign res_free  = !res_valid_q || res.ready;
	assign is_load   = (cmd.mode == calclk_pkg::MODE_SET) || (cmd.mode == calclk_pkg::MODE_SYNC);

	// Shared compare/subtract: one second per 1000 ms or per second tick
	assign step_amt = (mode_q == calclk_pkg::MODE_TICK_MS) ? calclk_pkg::MS_PER_SEC
	                                                       : calclk_pkg::ONE_SEC;
	assign step_go  = (state_q == calclk_pkg::ST_STEP) && (cnt_q >= step_amt);
	assign step_end = (state_q == calclk_pkg::ST_STEP) && !step_go;

	// Leap unit, shared between the load check and the running calendar
	assign leap_src = (state_q == calclk_pkg::ST_LEAP) ? ld_q.year : cur_q.year;

	// Load validation against the new year's month length
	assign ld_dim  = calclk_pkg::month_days(ld_q.month, leap_q);
	assign load_ok = (ld_dim != 5'd0) && (ld_q.day != 5'd0) && (ld_q.day <= ld_dim) &&
	                 (ld_q.hour <= calclk_pkg::LAST_HOUR) &&
	                 (ld_q.minute <= calclk_pkg::LAST_MINUTE) &&
	                 (ld_q.second <= calclk_pkg::LAST_SECOND);

	// One-second advance with the full cascade
	assign cur_dim = calclk_pkg::month_days(cur_q.month, leap_q);
	always_comb begin
		adv = cur_q;
		if (cur_q.second != calclk_pkg::LAST_SECOND) begin
			adv.second = cur_q.second + 6'd1;
		end else begin
			adv.second = 6'd0;
			if (cur_q.minute != calclk_pkg::LAST_MINUTE) begin
				adv.minute = cur_q.minute + 6'd1;
			end else begin
				adv.minute = 6'd0;
				if (cur_q.hour != calclk_pkg::LAST_HOUR) begin
					adv.hour = cur_q.hour + 5'd1;
				end else begin
					adv.hour = 5'd0;
					// out-of-range weekday restarts at 1
					if (cur_q.weekday == 3'd0 || cur_q.weekday == calclk_pkg::LAST_WDAY) begin
						adv.weekday = 3'd1;
					end else begin
						adv.weekday = cur_q.weekday + 3'd1;
					end
					if (cur_q.day < cur_dim) begin
						adv.day = cur_q.day + 5'd1;
					end else begin
						adv.day = 5'd1;
						if (cur_q.month != calclk_pkg::LAST_MONTH) begin
							adv.month = cur_q.month + 4'd1;
						end else begin
							adv.month = 4'd1;
							adv.year  = cur_q.year + 16'd1;
						end
					end
				end
			end
		end
	end

	// Sequencer next state
	always_comb begin
		state_d  = state_q;
		res_load = 1'b0;
		case (state_q)
			calclk_pkg::ST_IDLE: begin
				if (cmd_xfer) begin
					state_d = is_load ? calclk_pkg::ST_LEAP : calclk_pkg::ST_STEP;
				end
			end
			calclk_pkg::ST_STEP: begin
				if (step_end) begin
					state_d = calclk_pkg::ST_DONE;
				end
			end
			calclk_pkg::ST_LEAP: begin
				state_d = calclk_pkg::ST_LOAD;
			end
			calclk_pkg::ST_LOAD: begin
				state_d = calclk_pkg::ST_DONE;
			end
			calclk_pkg::ST_DONE: begin
				if (res_free) begin
					res_load = 1'b1;
					state_d  = calclk_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = calclk_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= calclk_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Calendar state, remainder and leap flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.year    <= calclk_pkg::YEAR_RESET;
			cur_q.month   <= calclk_pkg::MONTH_RESET;
			cur_q.day     <= calclk_pkg::DAY_RESET;
			cur_q.hour    <= 5'd0;
			cur_q.minute  <= 6'd0;
			cur_q.second  <= 6'd0;
			cur_q.weekday <= calclk_pkg::WEEKDAY_RESET;
			rem_q         <= '0;
			leap_q        <= 1'b0;
			acc_q         <= 1'b0;
		end else begin
			leap_q <= calclk_pkg::leap_year(leap_src);
			if (step_go) begin
				cur_q <= adv;
			end
			if (step_end) begin
				acc_q <= 1'b1;
				if (mode_q == calclk_pkg::MODE_TICK_MS) begin
					rem_q <= cnt_q[calclk_pkg::MsW-1:0];
				end
			end
			if (state_q == calclk_pkg::ST_LOAD) begin
				acc_q <= load_ok;
				if (load_ok) begin
					cur_q <= ld_q;
					if (mode_q == calclk_pkg::MODE_SYNC) begin
						rem_q <= '0;
					end
				end
			end
		end
	end

	// Command capture and step counter
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			mode_q     <= calclk_pkg::calclk_mode_t'(cmd.mode);
			ld_q.year    <= cmd.new_year;
			ld_q.month   <= cmd.new_month;
			ld_q.day     <= cmd.new_day;
			ld_q.hour    <= cmd.new_hour;
			ld_q.minute  <= cmd.new_minute;
			ld_q.second  <= cmd.new_second;
			ld_q.weekday <= cmd.new_weekday;
			if (cmd.mode == calclk_pkg::MODE_TICK_MS) begin
				cnt_q <= {{(calclk_pkg::CntW-calclk_pkg::MsW){1'b0}}, rem_q} +
				         {1'b0, cmd.elapsed};
			end else begin
				cnt_q <= {1'b0, cmd.elapsed};
			end
		end else if (step_go) begin
			cnt_q <= cnt_q - step_amt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_time_q <= cur_q;
			res_ms_q   <= rem_q;
			res_acc_q  <= acc_q;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.year     = res_time_q.year;
	assign res.month    = res_time_q.month;
	assign res.day      = res_time_q.day;
	assign res.hour     = res_time_q.hour;
	assign res.minute   = res_time_q.minute;
	assign res.second   = res_time_q.second;
	assign res.weekday  = res_time_q.weekday;
	assign res.millis   = res_ms_q;
	assign res.accepted = res_acc_q;

	// Checks
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(state_q == calclk_pkg::ST_DONE))
		else $error("result registered outside the final state");

	a_cnt_falls: assert property (@(posedge clk) disable iff (!arst_n)
		step_go |=> cnt_q < $past(cnt_q))
		else $error("step counter did not fall");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == calclk_pkg::ST_LOAD && !load_ok) |=> $stable(cur_q) && $stable(rem_q))
		else $error("rejected load changed the calendar");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q.second <= calclk_pkg::LAST_SECOND) && (cur_q.minute <= calclk_pkg::LAST_MINUTE) &&
		(cur_q.hour <= calclk_pkg::LAST_HOUR))
		else $error("time of day out of range");

	a_ms_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < calclk_pkg::MS_PER_SEC[calclk_pkg::MsW-1:0])
		else $error("millisecond remainder out of range");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer |=> !cmd.ready)
		else $error("command taken while a command is in progress");

endmodule

### tb/sv/calendar_clock_counter_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for calendar_clock_counter_core: directed table, then random
// load-and-tick sequences and raw noise, checked against an in-bench calendar predictor
// or a typed expectation. Depends on calclk_pkg, calclk_cmd_if, calclk_res_if and the core.
module calendar_clock_counter_core_tb;

	// One command and the state the block reports after it
	typedef struct packed {
		calclk_pkg::calclk_mode_t mode;
		logic [15:0]              elapsed;
		calclk_pkg::calclk_time_t load;
	} clk_cmd_t;

	typedef struct packed {
		calclk_pkg::calclk_time_t t;
		logic [9:0]               millis;
		logic                     accepted;
	} clk_snap_t;

	// Directed row: command, and a typed expectation where one is given
	typedef struct packed {
		calclk_pkg::calclk_mode_t mode;
		logic [15:0]              elapsed;
		calclk_pkg::calclk_time_t load;
		logic                     typed;
		clk_snap_t                want;
	} seed_row_t;

	localparam int ITEMS = 1450;
	localparam int DIR_N = 26;
	localparam int LONG_HOLD = 300;
	localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam calclk_pkg::calclk_time_t NO_LOAD = '0;
	localparam clk_snap_t NO_WANT = '0;
	localparam calclk_pkg::calclk_time_t EPOCH_1S = '{1970, 1, 1, 0, 0, 1, 4};

	localparam seed_row_t SEED_TAB [DIR_N] = '{
		'{calclk_pkg::MODE_TICK_SEC, 0, NO_LOAD, 1, '{'{1970, 1, 1, 0, 0, 0, 4}, 0, 1}},
		'{calclk_pkg::MODE_TICK_MS, 999, NO_LOAD, 1, '{'{1970, 1, 1, 0, 0, 0, 4}, 999, 1}},
		'{calclk_pkg::MODE_TICK_MS, 1, NO_LOAD, 1, '{EPOCH_1S, 0, 1}},
		// rejected loads: each field out of range in turn
		'{calclk_pkg::MODE_SET, 0, '{2020, 0, 10, 10, 10, 10, 3}, 1, '{EPOCH_1S, 0, 0}},
		'{calclk_pkg::MODE_SET, 0, '{2020, 13, 10, 10, 10, 10, 3}, 1, '{EPOCH_1S, 0, 0}},
		'{calclk_pkg::MODE_SYNC, 0, '{2021, 5, 0, 8, 0, 0, 1}, 1, '{EPOCH_1S, 0, 0}},
		'{calclk_pkg::MODE_SET, 0, '{2021, 4, 31, 8, 0, 0, 1}, 1, '{EPOCH_1S, 0, 0}},
		'{calclk_pkg::MODE_SET, 0, '{2021, 6, 15, 24, 0, 0, 1}, 1, '{EPOCH_1S, 0, 0}},
		'{calclk_pkg::MODE_SYNC, 0, '{2021, 6, 15, 12, 60, 0, 1}, 1, '{EPOCH_1S, 0, 0}},
		'{calclk_pkg::MODE_SET, 0, '{2021, 6, 15, 12, 30, 60, 1}, 1, '{EPOCH_1S, 0, 0}},
		'{calclk_pkg::MODE_SET, 65535, '{65535, 15, 31, 31, 63, 63, 7}, 1,
			'{EPOCH_1S, 0, 0}},
		'{calclk_pkg::MODE_SYNC, 0, NO_LOAD, 1, '{EPOCH_1S, 0, 0}},
		// set keeps the remainder; 400-year leap day
		'{calclk_pkg::MODE_TICK_MS, 500, NO_LOAD, 1, '{EPOCH_1S, 500, 1}},
		'{calclk_pkg::MODE_SET, 0, '{2000, 2, 29, 23, 59, 59, 0}, 1,
			'{'{2000, 2, 29, 23, 59, 59, 0}, 500, 1}},
		'{calclk_pkg::MODE_TICK_MS, 65535, NO_LOAD, 0, NO_WANT},
		'{calclk_pkg::MODE_SET, 0, '{1900, 2, 29, 0, 0, 0, 1}, 0, NO_WANT},
		'{calclk_pkg::MODE_SET, 0, '{2023, 2, 29, 0, 0, 0, 1}, 0, NO_WANT},
		'{calclk_pkg::MODE_SYNC, 0, '{2024, 2, 29, 12, 0, 0, 5}, 1,
			'{'{2024, 2, 29, 12, 0, 0, 5}, 0, 1}},
		'{calclk_pkg::MODE_SYNC, 0, '{2023, 2, 28, 23, 59, 59, 6}, 1,
			'{'{2023, 2, 28, 23, 59, 59, 6}, 0, 1}},
		'{calclk_pkg::MODE_TICK_SEC, 1, NO_LOAD, 1, '{'{2023, 3, 1, 0, 0, 0, 7}, 0, 1}},
		// year wrap
		'{calclk_pkg::MODE_SYNC, 0, '{65535, 12, 31, 23, 59, 59, 7}, 1,
			'{'{65535, 12, 31, 23, 59, 59, 7}, 0, 1}},
		'{calclk_pkg::MODE_TICK_SEC, 1, NO_LOAD, 1, '{'{0, 1, 1, 0, 0, 0, 1}, 0, 1}},
		'{calclk_pkg::MODE_SET, 0, '{0, 2, 29, 0, 0, 0, 2}, 1,
			'{'{0, 2, 29, 0, 0, 0, 2}, 0, 1}},
		'{calclk_pkg::MODE_TICK_SEC, 65535, NO_LOAD, 0, NO_WANT},
		// century non-leap year, weekday 0 becomes 1 on rollover
		'{calclk_pkg::MODE_SYNC, 0, '{2100, 2, 28, 23, 59, 59, 0}, 1,
			'{'{2100, 2, 28, 23, 59, 59, 0}, 0, 1}},
		'{calclk_pkg::MODE_TICK_MS, 1000, NO_LOAD, 1, '{'{2100, 3, 1, 0, 0, 0, 1}, 0, 1}}
	};

	logic clk;
	logic arst_n;

	calclk_cmd_if cmd_ch ();
	calclk_res_if res_ch ();

	calendar_clock_counter_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// Predicted calendar and the queue of states still to be reported
	calclk_pkg::calclk_time_t cal_now;
	logic [9:0]               cal_ms;
	clk_snap_t                due_states [$];

	int          errors;
	int          n_sent;
	bit          idle_on;
	int unsigned work_budget;
	int unsigned cycle_no;

	function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
		if (m < 1 || m > 12)
			return 0;
		if (m == 2 && ((y % 400 == 0) || (y % 100 != 0 && y % 4 == 0)))
			return 29;
		return MONTH_LEN[m - 1];
	endfunction

	// One second forward through the whole cascade
	function automatic void next_second();
		if (cal_now.second < 59) begin
			cal_now.second = cal_now.second + 6'd1;
			return;
		end
		cal_now.second = 6'd0;
		if (cal_now.minute < 59) begin
			cal_now.minute = cal_now.minute + 6'd1;
			return;
		end
		cal_now.minute = 6'd0;
		if (cal_now.hour < 23) begin
			cal_now.hour = cal_now.hour + 5'd1;
			return;
		end
		cal_now.hour = 5'd0;
		if (cal_now.weekday < 1 || cal_now.weekday > 7)
			cal_now.weekday = 3'd1;
		else
			cal_now.weekday = 3'((cal_now.weekday % 7) + 1);
		if (cal_now.day < days_in_month(cal_now.year, cal_now.month)) begin
			cal_now.day = cal_now.day + 5'd1;
			return;
		end
		cal_now.day = 5'd1;
		if (cal_now.month < 12) begin
			cal_now.month = cal_now.month + 4'd1;
			return;
		end
		cal_now.month = 4'd1;
		cal_now.year = cal_now.year + 16'd1;
	endfunction

	function automatic clk_snap_t apply_cmd(clk_cmd_t c);
		int unsigned total;
		int unsigned dim;
		int unsigned k;
		clk_snap_t s;
		s.accepted = 1'b0;
		case (c.mode)
			calclk_pkg::MODE_TICK_MS: begin
				total = cal_ms + c.elapsed;
				cal_ms = 10'(total % 1000);
				for (k = 0; k < total / 1000; k++)
					next_second();
				s.accepted = 1'b1;
			end
			calclk_pkg::MODE_TICK_SEC: begin
				for (k = 0; k < c.elapsed; k++)
					next_second();
				s.accepted = 1'b1;
			end
			default: begin
				dim = days_in_month(c.load.year, c.load.month);
				if (dim != 0 && c.load.day >= 1 && c.load.day <= dim && c.load.hour < 24
						&& c.load.minute < 60 && c.load.second < 60) begin
					cal_now = c.load;
					if (c.mode == calclk_pkg::MODE_SYNC)
						cal_ms = '0;
					s.accepted = 1'b1;
				end
			end
		endcase
		s.t = cal_now;
		s.millis = cal_ms;
		return s;
	endfunction

	// Valid load, mostly just short of a day, month or year boundary; sometimes spoilt
	function automatic clk_cmd_t pick_load();
		int unsigned y;
		int unsigned m;
		int unsigned dim;
		bit near;
		clk_cmd_t c;
		case ($urandom_range(0, 7))
			0: y = $urandom_range(0, 65535);
			1: y = 65535;
			2: y = 100 * $urandom_range(0, 655);
			3: y = 4 * $urandom_range(0, 16383);
			default: y = $urandom_range(1890, 2110);
		endcase
		near = ($urandom_range(0, 3) != 0);
		m = (near && $urandom_range(0, 2) == 0) ? 12 : $urandom_range(1, 12);
		dim = days_in_month(y, m);
		c.mode = $urandom_range(0, 1) ? calclk_pkg::MODE_SET : calclk_pkg::MODE_SYNC;
		c.elapsed = 16'($urandom);
		c.load.year = 16'(y);
		c.load.month = 4'(m);
		c.load.weekday = 3'($urandom_range(0, 7));
		if (near) begin
			c.load.day = 5'(dim - $urandom_range(0, 1));
			c.load.hour = 5'd23;
			c.load.minute = 6'd59;
			c.load.second = 6'($urandom_range(30, 59));
		end else begin
			c.load.day = 5'($urandom_range(1, dim));
			c.load.hour = 5'($urandom_range(0, 23));
			c.load.minute = 6'($urandom_range(0, 59));
			c.load.second = 6'($urandom_range(0, 59));
		end
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 4))
				0: c.load.month = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
				1: c.load.day = (dim < 31) ? 5'($urandom_range(dim + 1, 31)) : 5'd0;
				2: c.load.hour = 5'($urandom_range(24, 31));
				3: c.load.minute = 6'($urandom_range(60, 63));
				default: c.load.second = 6'($urandom_range(60, 63));
			endcase
		end
		return c;
	endfunction

	// Tick with mostly short spans; a rare long one
	function automatic clk_cmd_t pick_tick();
		logic [63:0] rb;
		int unsigned r;
		clk_cmd_t c;
		rb = {$urandom, $urandom};
		c = rb[62:0];
		if ($urandom_range(0, 1)) begin
			c.mode = calclk_pkg::MODE_TICK_MS;
			c.elapsed = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(0, 2500));
		end else begin
			c.mode = calclk_pkg::MODE_TICK_SEC;
			r = $urandom_range(0, 399);
			if (r == 0)
				c.elapsed = 16'($urandom_range(0, 65535));
			else if (r < 40)
				c.elapsed = 16'($urandom_range(0, 5000));
			else
				c.elapsed = 16'($urandom_range(0, 90));
		end
		return c;
	endfunction

	// Any bit pattern; long second ticks trimmed most of the time
	function automatic clk_cmd_t pick_noise();
		logic [63:0] rb;
		clk_cmd_t c;
		rb = {$urandom, $urandom};
		c = rb[62:0];
		if (c.mode == calclk_pkg::MODE_TICK_SEC && $urandom_range(0, 99) != 0)
			c.elapsed[15:8] = '0;
		return c;
	endfunction

	function automatic void chk_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Offer one command, wait for its transfer, then record the expected state
	task automatic offer(input clk_cmd_t c, input bit typed, input clk_snap_t want);
		clk_snap_t s;
		int unsigned n;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 14);
			cmd_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		work_budget += 40 + ((c.mode == calclk_pkg::MODE_TICK_SEC) ? c.elapsed
			: (c.mode == calclk_pkg::MODE_TICK_MS) ? c.elapsed / 1000 + 1 : 0);
		cmd_ch.valid       <= 1'b1;
		cmd_ch.mode        <= c.mode;
		cmd_ch.elapsed     <= c.elapsed;
		cmd_ch.new_year    <= c.load.year;
		cmd_ch.new_month   <= c.load.month;
		cmd_ch.new_day     <= c.load.day;
		cmd_ch.new_hour    <= c.load.hour;
		cmd_ch.new_minute  <= c.load.minute;
		cmd_ch.new_second  <= c.load.second;
		cmd_ch.new_weekday <= c.load.weekday;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		s = apply_cmd(c);
		due_states.push_back(typed ? want : s);
		n_sent++;
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: limit grows with the work offered so far
	initial begin
		cycle_no = 0;
		while (cycle_no < 4 * work_budget + 20000) begin
			@(posedge clk);
			cycle_no++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Result side: random stalls, one long hold-off, and the checks
	initial begin : res_side
		int unsigned hold_left;
		int unsigned taken;
		bit long_done;
		clk_snap_t want;
		hold_left = 0;
		taken = 0;
		long_done = 1'b0;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				taken++;
				if (due_states.size() == 0) begin
					$display("%0t unexpected result: expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
						$time, res_ch.year, res_ch.month, res_ch.day, res_ch.hour,
						res_ch.minute, res_ch.second);
					errors++;
				end else begin
					want = due_states.pop_front();
					chk_field("year", want.t.year, res_ch.year);
					chk_field("month", want.t.month, res_ch.month);
					chk_field("day", want.t.day, res_ch.day);
					chk_field("hour", want.t.hour, res_ch.hour);
					chk_field("minute", want.t.minute, res_ch.minute);
					chk_field("second", want.t.second, res_ch.second);
					chk_field("weekday", want.t.weekday, res_ch.weekday);
					chk_field("millis", want.millis, res_ch.millis);
					chk_field("accepted", want.accepted, res_ch.accepted);
				end
			end
			// long hold-off once, so the core fills and back-pressures the command side
			if (!long_done && taken == 400) begin
				long_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				hold_left = $urandom_range(0, 13);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus
	initial begin : cmd_side
		int i;
		int k;
		clk_cmd_t c;
		errors = 0;
		n_sent = 0;
		idle_on = 1'b1;
		work_budget = LONG_HOLD;
		cal_now = '{calclk_pkg::YEAR_RESET, calclk_pkg::MONTH_RESET, calclk_pkg::DAY_RESET,
			0, 0, 0, calclk_pkg::WEEKDAY_RESET};
		cal_ms = '0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = calclk_pkg::MODE_TICK_MS;
		cmd_ch.elapsed = '0;
		cmd_ch.new_year = '0;
		cmd_ch.new_month = '0;
		cmd_ch.new_day = '0;
		cmd_ch.new_hour = '0;
		cmd_ch.new_minute = '0;
		cmd_ch.new_second = '0;
		cmd_ch.new_weekday = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < DIR_N; i++) begin
			c.mode = SEED_TAB[i].mode;
			c.elapsed = SEED_TAB[i].elapsed;
			c.load = SEED_TAB[i].load;
			offer(c, SEED_TAB[i].typed, SEED_TAB[i].want);
		end

		// random: mostly a load followed by ticks, some raw noise; quiet at the end
		while (n_sent < ITEMS) begin
			idle_on = (n_sent < ITEMS - 150) && ($urandom_range(0, 5) != 0);
			if ($urandom_range(0, 9) < 7) begin
				offer(pick_load(), 1'b0, NO_WANT);
				k = $urandom_range(1, 6);
				repeat (k) offer(pick_tick(), 1'b0, NO_WANT);
			end else begin
				k = $urandom_range(1, 4);
				repeat (k) offer(pick_noise(), 1'b0, NO_WANT);
			end
		end
		cmd_ch.valid <= 1'b0;

		// drain
		while (due_states.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
